FILE: hw/rtl/nts_pkg.sv
// nts_pkg: shared types and constants of the noise triggered motor sequencer
// used by nts_step and noise_triggered_motor_sequencer_core; no dependencies

package nts_pkg;

  // sequencer modes, also the code carried in the mode field of a result word
  typedef enum logic [2:0] {
    MODE_IDLE    = 3'd0,
    MODE_QUALIFY = 3'd1,
    MODE_ACTIVE  = 3'd2,
    MODE_RELEASE = 3'd3,
    MODE_LOCKOUT = 3'd4
  } mode_e;

  // configuration register indexes
  localparam int unsigned CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] CFG_TRIGGER_LEVEL = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_QUALIFY_TIME  = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_RELEASE_TIME  = 2'd2;
  localparam logic [CfgIdxW-1:0] CFG_MOTOR_DUTY    = 2'd3;

  // configuration register reset values
  localparam logic [6:0]  TRIGGER_LEVEL_RST = 7'd80;
  localparam logic [31:0] QUALIFY_TIME_RST  = 32'd500;
  localparam logic [31:0] RELEASE_TIME_RST  = 32'd3000;
  localparam logic [7:0]  MOTOR_DUTY_RST    = 8'd255;

  // input word: one sound level sample with motor service status
  typedef struct packed {
    logic [7:0]  level_percent;
    logic [31:0] now_ms;
    logic        motor_running;
    logic        motor_locked;
    logic        start_ok;
  } in_t;

  // result word
  typedef struct packed {
    logic [2:0] mode;
    logic       start_request;
    logic [7:0] start_duty;
    logic       stop_request;
    logic       clear_lockout_request;
    logic       noise_detected;
  } out_t;

  // configuration register set
  typedef struct packed {
    logic [6:0]  trigger_level;
    logic [31:0] qualify_time_ms;
    logic [31:0] release_time_ms;
    logic [7:0]  motor_duty;
  } cfg_t;

  // sequencer state: mode and the time it was entered
  typedef struct packed {
    mode_e       mode;
    logic [31:0] entered_ms;
  } state_t;

endpackage

FILE: hw/rtl/nts_step.sv
// nts_step: combinational next-state and result logic for one sample
// depends on nts_pkg

module nts_step (
  input  nts_pkg::cfg_t   cfg_i,
  input  nts_pkg::state_t state_i,
  input  nts_pkg::in_t    sample_i,
  output nts_pkg::state_t state_o,
  output nts_pkg::out_t   result_o
);

  logic          above;
  nts_pkg::mode_e mode;
  nts_pkg::mode_e nxt_mode;
  logic [31:0]   entered;
  logic [31:0]   nxt_entered;
  logic [31:0]   elapsed;
  logic          start_req;
  logic          stop_req;
  logic          clear_req;

  always_comb begin
    // noise means strictly above the trigger level
    above = sample_i.level_percent > {1'b0, cfg_i.trigger_level};

    // unknown codes fall back to idle
    mode    = state_i.mode;
    entered = state_i.entered_ms;
    if (mode > nts_pkg::MODE_LOCKOUT) begin
      mode = nts_pkg::MODE_IDLE;
    end

    // lockout reported by the motor service overrides everything
    if (sample_i.motor_locked && (mode != nts_pkg::MODE_LOCKOUT)) begin
      mode    = nts_pkg::MODE_LOCKOUT;
      entered = sample_i.now_ms;
    end

    // time in the current mode, modulo 2^32
    elapsed = sample_i.now_ms - entered;

    nxt_mode    = mode;
    nxt_entered = entered;
    start_req   = 1'b0;
    stop_req    = 1'b0;
    clear_req   = 1'b0;

    // mode transitions
    unique case (mode)
      nts_pkg::MODE_IDLE: begin
        if (above) begin
          nxt_mode = nts_pkg::MODE_QUALIFY;
        end
      end
      nts_pkg::MODE_QUALIFY: begin
        if (!above) begin
          nxt_mode = nts_pkg::MODE_IDLE;
        end else if (elapsed >= cfg_i.qualify_time_ms) begin
          start_req = 1'b1;
          if (sample_i.start_ok) begin
            nxt_mode = nts_pkg::MODE_ACTIVE;
          end
        end
      end
      nts_pkg::MODE_ACTIVE: begin
        if (!sample_i.motor_running) begin
          nxt_mode = sample_i.motor_locked ? nts_pkg::MODE_LOCKOUT : nts_pkg::MODE_IDLE;
        end else if (!above) begin
          nxt_mode = nts_pkg::MODE_RELEASE;
        end
      end
      nts_pkg::MODE_RELEASE: begin
        if (!sample_i.motor_running) begin
          nxt_mode = sample_i.motor_locked ? nts_pkg::MODE_LOCKOUT : nts_pkg::MODE_IDLE;
        end else if (above) begin
          nxt_mode = nts_pkg::MODE_ACTIVE;
        end else if (elapsed >= cfg_i.release_time_ms) begin
          stop_req = 1'b1;
          nxt_mode = nts_pkg::MODE_IDLE;
        end
      end
      nts_pkg::MODE_LOCKOUT: begin
        // noise restarts the silence timer
        if (above) begin
          nxt_entered = sample_i.now_ms;
        end else if (elapsed >= cfg_i.release_time_ms) begin
          clear_req = 1'b1;
          nxt_mode  = nts_pkg::MODE_IDLE;
        end
      end
      default: begin
        nxt_mode = nts_pkg::MODE_IDLE;
      end
    endcase

    // entry time moves on a real change of mode, and in lockout when noise restarts the silence timer
    if (nxt_mode != mode) begin
      nxt_entered = sample_i.now_ms;
    end

    state_o.mode       = nxt_mode;
    state_o.entered_ms = nxt_entered;

    result_o.mode                  = nxt_mode;
    result_o.start_request         = start_req;
    result_o.start_duty            = start_req ? cfg_i.motor_duty : 8'd0;
    result_o.stop_request          = stop_req;
    result_o.clear_lockout_request = clear_req;
    result_o.noise_detected        = above;
  end

endmodule

FILE: hw/rtl/noise_triggered_motor_sequencer_core.sv
// noise_triggered_motor_sequencer_core: top level of the noise triggered motor sequencer
// depends on nts_pkg and nts_step

// Takes one sound level sample per cycle, while out_stall_i is low, and returns
// exactly one result word per sample, in order. A sample is captured in an input
// register, evaluated against the sequencer state, and its result lands in an
// output register, from which it is offered; a new sample can be taken on every
// cycle while out_stall_i is low; the 32-bit elapsed-time subtract and compare
// sets the critical path. While the output register is held by out_stall_i
// the input register still takes one more sample before in_stall_o rises. The
// configuration registers are written through the cfg port, which is always
// ready, and should only be written while no sample is in flight.
module noise_triggered_motor_sequencer_core (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // sample input
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  nts_pkg::in_t                    in_data_i,
  // result output
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output nts_pkg::out_t                   out_data_o,
  // configuration write port
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [nts_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  logic [31:0]                     cfg_data_i
);

  nts_pkg::cfg_t   cfg_q;
  nts_pkg::state_t state_q;
  nts_pkg::state_t state_d;
  nts_pkg::in_t    smp_q;
  nts_pkg::out_t   res_d;
  nts_pkg::out_t   res_q;
  logic            smp_valid_q;
  logic            smp_valid_d;
  logic            res_valid_q;
  logic            res_valid_d;
  logic            in_acc;
  logic            smp_adv;

  // handshake and stage control
  assign smp_adv     = smp_valid_q && (!res_valid_q || !out_stall_i);
  assign in_stall_o  = smp_valid_q && !smp_adv;
  assign in_acc      = in_valid_i && !in_stall_o;
  assign smp_valid_d = in_acc ? 1'b1 : (smp_adv ? 1'b0 : smp_valid_q);
  assign res_valid_d = smp_adv || (res_valid_q && out_stall_i);

  assign out_valid_o = res_valid_q;
  assign out_data_o  = res_q;
  assign cfg_ready_o = 1'b1;

  // per-sample evaluation
  nts_step u_step (
    .cfg_i    (cfg_q),
    .state_i  (state_q),
    .sample_i (smp_q),
    .state_o  (state_d),
    .result_o (res_d)
  );

  // control state, sequencer state and configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      smp_valid_q           <= 1'b0;
      res_valid_q           <= 1'b0;
      state_q.mode          <= nts_pkg::MODE_IDLE;
      state_q.entered_ms    <= 32'd0;
      cfg_q.trigger_level   <= nts_pkg::TRIGGER_LEVEL_RST;
      cfg_q.qualify_time_ms <= nts_pkg::QUALIFY_TIME_RST;
      cfg_q.release_time_ms <= nts_pkg::RELEASE_TIME_RST;
      cfg_q.motor_duty      <= nts_pkg::MOTOR_DUTY_RST;
    end else begin
      smp_valid_q <= smp_valid_d;
      res_valid_q <= res_valid_d;
      if (smp_adv) begin
        state_q <= state_d;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        unique case (cfg_index_i)
          nts_pkg::CFG_TRIGGER_LEVEL: cfg_q.trigger_level   <= cfg_data_i[6:0];
          nts_pkg::CFG_QUALIFY_TIME:  cfg_q.qualify_time_ms <= cfg_data_i;
          nts_pkg::CFG_RELEASE_TIME:  cfg_q.release_time_ms <= cfg_data_i;
          nts_pkg::CFG_MOTOR_DUTY:    cfg_q.motor_duty      <= cfg_data_i[7:0];
          default: begin
          end
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      smp_q <= in_data_i;
    end
    if (smp_adv) begin
      res_q <= res_d;
    end
  end

  // checks on the result word
  a_duty_only_with_start : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_data_o.start_request) |-> (out_data_o.start_duty == 8'd0))
    else $error("start duty without start request");

  a_one_request : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> $onehot0({out_data_o.start_request, out_data_o.stop_request,
                              out_data_o.clear_lockout_request}))
    else $error("more than one motor request in a result");

  a_stop_to_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_data_o.stop_request || out_data_o.clear_lockout_request))
      |-> (out_data_o.mode == nts_pkg::MODE_IDLE))
    else $error("stop or lockout clear without return to idle");

  a_state_tracks_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    smp_adv |=> (out_data_o.mode == state_q.mode))
    else $error("result mode differs from sequencer state");

endmodule

FILE: tb/sv/tb_top.sv
// tb_top: self-checking testbench for noise_triggered_motor_sequencer_core
// holds a scoreboard class with its own model of the sequencer; depends on nts_pkg

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LONG_HOLD = 200;

  // scoreboard: mirrors the sequencer and queues the expected result words
  class seq_scoreboard;
    logic [6:0]     trig_level;
    logic [31:0]    qualify_ms;
    logic [31:0]    release_ms;
    logic [7:0]     duty;
    nts_pkg::mode_e mode;
    logic [31:0]    entered;
    nts_pkg::out_t  pending_results[$];
    nts_pkg::out_t  last_out;
    int             noted;
    int             checked;
    int             failures;

    function new();
      trig_level = nts_pkg::TRIGGER_LEVEL_RST;
      qualify_ms = nts_pkg::QUALIFY_TIME_RST;
      release_ms = nts_pkg::RELEASE_TIME_RST;
      duty       = nts_pkg::MOTOR_DUTY_RST;
      mode       = nts_pkg::MODE_IDLE;
      entered    = '0;
      last_out   = '0;
      noted      = 0;
      checked    = 0;
      failures   = 0;
    endfunction

    function void set_config(logic [6:0] t, logic [31:0] q, logic [31:0] r, logic [7:0] d);
      trig_level = t;
      qualify_ms = q;
      release_ms = r;
      duty       = d;
    endfunction

    // a move to the same mode keeps the entry time
    function void move_to(nts_pkg::mode_e m, logic [31:0] t);
      if (mode != m) begin
        mode    = m;
        entered = t;
      end
    endfunction

    function nts_pkg::out_t predict_step(nts_pkg::in_t s);
      nts_pkg::out_t r;
      logic          above;
      logic [31:0]   elapsed;
      r     = '0;
      above = s.level_percent > {1'b0, trig_level};
      // a reported lockout overrides whatever mode we are in
      if (s.motor_locked && mode != nts_pkg::MODE_LOCKOUT)
        move_to(nts_pkg::MODE_LOCKOUT, s.now_ms);
      elapsed = s.now_ms - entered;
      case (mode)
        nts_pkg::MODE_QUALIFY: begin
          if (!above) begin
            move_to(nts_pkg::MODE_IDLE, s.now_ms);
          end else if (elapsed >= qualify_ms) begin
            r.start_request = 1'b1;
            if (s.start_ok) move_to(nts_pkg::MODE_ACTIVE, s.now_ms);
          end
        end
        nts_pkg::MODE_ACTIVE: begin
          if (!s.motor_running) begin
            move_to(s.motor_locked ? nts_pkg::MODE_LOCKOUT : nts_pkg::MODE_IDLE, s.now_ms);
          end else if (!above) begin
            move_to(nts_pkg::MODE_RELEASE, s.now_ms);
          end
        end
        nts_pkg::MODE_RELEASE: begin
          if (!s.motor_running) begin
            move_to(s.motor_locked ? nts_pkg::MODE_LOCKOUT : nts_pkg::MODE_IDLE, s.now_ms);
          end else if (above) begin
            move_to(nts_pkg::MODE_ACTIVE, s.now_ms);
          end else if (elapsed >= release_ms) begin
            r.stop_request = 1'b1;
            move_to(nts_pkg::MODE_IDLE, s.now_ms);
          end
        end
        nts_pkg::MODE_LOCKOUT: begin
          // noise restarts the silence timer
          if (above) begin
            entered = s.now_ms;
          end else if (elapsed >= release_ms) begin
            r.clear_lockout_request = 1'b1;
            move_to(nts_pkg::MODE_IDLE, s.now_ms);
          end
        end
        default: begin
          if (above) move_to(nts_pkg::MODE_QUALIFY, s.now_ms);
        end
      endcase
      r.mode           = mode;
      r.start_duty     = r.start_request ? duty : 8'd0;
      r.noise_detected = above;
      last_out         = r;
      return r;
    endfunction

    function void note_sample(nts_pkg::in_t s);
      pending_results.push_back(predict_step(s));
      noted++;
    endfunction

    function string describe(nts_pkg::out_t o);
      return $sformatf("mode %0d start %0b duty %0d stop %0b clear %0b noise %0b",
                       o.mode, o.start_request, o.start_duty, o.stop_request,
                       o.clear_lockout_request, o.noise_detected);
    endfunction

    function void check_result(nts_pkg::out_t got);
      nts_pkg::out_t exp;
      checked++;
      if (pending_results.size() == 0) begin
        failures++;
        if (failures <= 10) $display("result word %0d with nothing expected: %s",
                                     checked, describe(got));
        return;
      end
      exp = pending_results.pop_front();
      if (got.mode !== exp.mode || got.start_request !== exp.start_request ||
          got.start_duty !== exp.start_duty || got.stop_request !== exp.stop_request ||
          got.clear_lockout_request !== exp.clear_lockout_request ||
          got.noise_detected !== exp.noise_detected) begin
        failures++;
        if (failures <= 10) $display("result word %0d mismatch: expected %s / got %s",
                                     checked, describe(exp), describe(got));
      end
    endfunction
  endclass

  logic                         clk_i = 1'b0;
  logic                         rst_ni = 1'b0;
  logic                         in_valid_i = 1'b0;
  logic                         in_stall_o;
  nts_pkg::in_t                 in_data_i = '0;
  logic                         out_valid_o;
  logic                         out_stall_i = 1'b0;
  nts_pkg::out_t                out_data_o;
  logic                         cfg_valid_i = 1'b0;
  logic                         cfg_ready_o;
  logic [nts_pkg::CfgIdxW-1:0]  cfg_index_i = nts_pkg::CFG_TRIGGER_LEVEL;
  logic [31:0]                  cfg_data_i = '0;

  seq_scoreboard sb = new();

  bit          tx_burst;
  bit          rx_burst;
  bit          long_hold_req;
  bit          noisy;
  bit          svc_running;
  bit          svc_locked;
  logic [31:0] stim_now;
  int          cfg_loads;

  noise_triggered_motor_sequencer_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  // 2 ns clock
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // watch both channels at the rising edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) sb.note_sample(in_data_i);
      if (out_valid_o && !out_stall_i) sb.check_result(out_data_o);
    end
  end

  // result sink: random stall before each word, one long hold-off on request
  initial begin : result_sink
    int n;
    forever begin
      n = rx_burst ? 0 : $urandom_range(0, 7);
      if (long_hold_req) begin
        n += LONG_HOLD;
        long_hold_req = 1'b0;
      end
      if ($urandom_range(0, 39) == 0) rx_burst = !rx_burst;
      if (n > 0) begin
        out_stall_i <= 1'b1;
        repeat (n) @(negedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!(out_valid_o && rst_ni));
      @(negedge clk_i);
    end
  end

  // returns at a falling edge with the accepted word still on the bus
  task automatic send_sample(nts_pkg::in_t s);
    int gap;
    gap = tx_burst ? 0 : $urandom_range(0, 7);
    if ($urandom_range(0, 39) == 0) tx_burst = !tx_burst;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= s;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
  endtask

  task automatic wait_for_results();
    in_valid_i <= 1'b0;
    while (sb.pending_results.size() != 0) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [nts_pkg::CfgIdxW-1:0] idx, logic [31:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
  endtask

  // waits until no word is in flight, then writes the registers
  task automatic load_config(logic [6:0] t, logic [31:0] q, logic [31:0] r, logic [7:0] d);
    wait_for_results();
    write_reg(nts_pkg::CFG_TRIGGER_LEVEL, {25'd0, t});
    write_reg(nts_pkg::CFG_QUALIFY_TIME, q);
    write_reg(nts_pkg::CFG_RELEASE_TIME, r);
    write_reg(nts_pkg::CFG_MOTOR_DUTY, {24'd0, d});
    cfg_valid_i <= 1'b0;
    sb.set_config(t, q, r, d);
    cfg_loads++;
  endtask

  function automatic nts_pkg::in_t sample_word(logic [7:0] lvl, logic [31:0] t, logic run,
                                               logic lock, logic ok);
    nts_pkg::in_t s;
    s.level_percent = lvl;
    s.now_ms        = t;
    s.motor_running = run;
    s.motor_locked  = lock;
    s.start_ok      = ok;
    return s;
  endfunction

  // noise episodes, timestamps aimed at the qualify and release boundaries
  function automatic nts_pkg::in_t next_sample();
    nts_pkg::in_t s;
    logic [31:0]  span;
    int           lo;
    int           hi;
    if ($urandom_range(0, 9) == 0) noisy = !noisy;
    lo = sb.trig_level + 1;
    hi = (sb.trig_level >= 7'd100) ? 255 : 100;
    if ($urandom_range(0, 15) == 0) s.level_percent = 8'($urandom);
    else if (noisy) s.level_percent = 8'($urandom_range(lo, hi));
    else s.level_percent = 8'($urandom_range(0, sb.trig_level));
    span = (sb.qualify_ms > sb.release_ms) ? sb.qualify_ms : sb.release_ms;
    if (span > 32'd1000000) span = 32'h3fff_ffff;
    else span = span / 3 + 1;
    case ($urandom_range(0, 15))
      0:       stim_now = stim_now;
      1:       stim_now = $urandom;
      2, 3:    stim_now = sb.entered + sb.qualify_ms - 32'd1 + $urandom_range(0, 2);
      4, 5:    stim_now = sb.entered + sb.release_ms - 32'd1 + $urandom_range(0, 2);
      default: stim_now = stim_now + $urandom_range(0, span);
    endcase
    s.now_ms        = stim_now;
    s.motor_running = svc_running ^ ($urandom_range(0, 19) == 0);
    s.motor_locked  = svc_locked ^ ($urandom_range(0, 19) == 0);
    s.start_ok      = $urandom_range(0, 3) != 0;
    return s;
  endfunction

  // random samples; the motor service follows the requests we predicted
  task automatic run_phase(int count, int hold_at, int pause_at);
    nts_pkg::in_t  s;
    nts_pkg::out_t o;
    for (int i = 0; i < count; i++) begin
      if (i == hold_at) long_hold_req = 1'b1;
      if (i == pause_at) wait_for_results();
      s = next_sample();
      send_sample(s);
      o = sb.last_out;
      if (o.start_request && s.start_ok) svc_running = 1'b1;
      if (o.stop_request) svc_running = 1'b0;
      if (o.clear_lockout_request) svc_locked = 1'b0;
      if ($urandom_range(0, 99) == 0) begin
        svc_locked  = 1'b1;
        svc_running = 1'b0;
      end
      if ($urandom_range(0, 149) == 0) svc_running = 1'b0;
    end
  endtask

  initial begin : stimulus
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed walk through every mode under the reset settings
    send_sample(sample_word(8'd0,   32'd0,    1'b0, 1'b0, 1'b1));
    send_sample(sample_word(8'd80,  32'd10,   1'b0, 1'b0, 1'b1));
    send_sample(sample_word(8'd81,  32'd100,  1'b0, 1'b0, 1'b1));
    send_sample(sample_word(8'd255, 32'd599,  1'b0, 1'b0, 1'b1));
    // start refused, then accepted
    send_sample(sample_word(8'd100, 32'd600,  1'b0, 1'b0, 1'b0));
    send_sample(sample_word(8'd100, 32'd601,  1'b0, 1'b0, 1'b1));
    send_sample(sample_word(8'd90,  32'd700,  1'b1, 1'b0, 1'b1));
    send_sample(sample_word(8'd0,   32'd800,  1'b1, 1'b0, 1'b1));
    send_sample(sample_word(8'd90,  32'd900,  1'b1, 1'b0, 1'b1));
    send_sample(sample_word(8'd0,   32'd1000, 1'b1, 1'b0, 1'b1));
    send_sample(sample_word(8'd0,   32'd3999, 1'b1, 1'b0, 1'b1));
    send_sample(sample_word(8'd0,   32'd4000, 1'b1, 1'b0, 1'b1));
    // motor stops by itself while active
    send_sample(sample_word(8'd90,  32'd4100, 1'b0, 1'b0, 1'b1));
    send_sample(sample_word(8'd90,  32'd4600, 1'b0, 1'b0, 1'b1));
    send_sample(sample_word(8'd90,  32'd4700, 1'b0, 1'b0, 1'b1));
    // forced lockout, noise restarts the silence timer, then rearm
    send_sample(sample_word(8'd50,  32'd5000, 1'b0, 1'b1, 1'b0));
    send_sample(sample_word(8'd90,  32'd7000, 1'b0, 1'b1, 1'b0));
    send_sample(sample_word(8'd0,   32'd9999, 1'b0, 1'b0, 1'b0));
    send_sample(sample_word(8'd0,   32'd10000, 1'b0, 1'b0, 1'b1));
    // qualifying across the timestamp wrap
    send_sample(sample_word(8'd90,  32'hffff_ff00, 1'b0, 1'b0, 1'b1));
    send_sample(sample_word(8'd90,  32'h0000_00f4, 1'b0, 1'b0, 1'b1));
    send_sample(sample_word(8'd0,   32'h0000_0100, 1'b1, 1'b0, 1'b0));
    stim_now = 32'h0000_0100;

    // extremes first, then the reset settings, then random settings
    load_config(7'd0, 32'd0, 32'd0, 8'd0);
    run_phase(200, -1, -1);
    load_config(7'd100, 32'hffff_ffff, 32'hffff_ffff, 8'd255);
    run_phase(200, -1, -1);
    load_config(nts_pkg::TRIGGER_LEVEL_RST, nts_pkg::QUALIFY_TIME_RST,
                nts_pkg::RELEASE_TIME_RST, nts_pkg::MOTOR_DUTY_RST);
    run_phase(300, 40, -1);
    for (int p = 0; p < 5; p++) begin
      load_config(7'($urandom_range(0, 100)), $urandom_range(0, 200),
                  $urandom_range(0, 400), 8'($urandom));
      run_phase(250, -1, (p == 1) ? 120 : -1);
    end

    wait_for_results();
    repeat (8) @(negedge clk_i);
    $display("%0d samples over %0d register settings, %0d result words checked",
             sb.noted, cfg_loads, sb.checked);
    if (sb.pending_results.size() != 0)
      $display("%0d result words never arrived", sb.pending_results.size());
    $display("%0d failing result words", sb.failures);
    if (sb.failures == 0 && sb.pending_results.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // watchdog
  initial begin : watchdog
    #1000000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
